[rtl/neh_pkg.sv]
// Shared constants, types and helpers for the navigation health supervisor.
package neh_pkg;

  // Timers saturate at the top of this width; every threshold fits below it
  localparam int TimeW = 26;
  typedef logic [TimeW-1:0] time_t;

  // Request function codes
  localparam logic [1:0] FuncTick    = 2'd0;
  localparam logic [1:0] FuncImpact  = 2'd1;
  localparam logic [1:0] FuncReloc   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CfgDegradedAfter = 3'd0;
  localparam logic [2:0] CfgLostAfter     = 3'd1;
  localparam logic [2:0] CfgRecoverHold   = 3'd2;
  localparam logic [2:0] CfgImpactBlind   = 3'd3;
  localparam logic [2:0] CfgImpactToLost  = 3'd4;

  // Configuration reset values
  localparam time_t RstDegradedAfter = 26'd500000;
  localparam time_t RstLostAfter     = 26'd2000000;
  localparam time_t RstRecoverHold   = 26'd300000;
  localparam time_t RstImpactBlind   = 26'd200000;

  // Validity codes
  localparam logic [1:0] ValInvalid  = 2'd0;
  localparam logic [1:0] ValDegraded = 2'd1;
  localparam logic [1:0] ValValid    = 2'd2;

  // Plausible tick length
  localparam logic [15:0] DtMinUs = 16'd500;
  localparam logic [15:0] DtMaxUs = 16'd50000;

  localparam logic [15:0] GoodFramesNeeded = 16'd5;

  // Quality: q = floor(Y / 78125)
  //   tracking class: Y = 640 * (4000000 - min(t, 1000000))
  //   aided class:    Y = 512 * (3500000 - min(t, 2500000))
  localparam time_t       TrkTimeCap = 26'd1000000;
  localparam logic [21:0] TrkBase    = 22'd4000000;
  localparam time_t       AidTimeCap = 26'd2500000;
  localparam logic [21:0] AidBase    = 22'd3500000;
  localparam logic [31:0] QDivisor   = 32'd78125;
  // floor(2^32 / 78125); underestimates the quotient by at most one
  localparam logic [15:0] QRecip     = 16'd54975;

  // Saturating timer add
  function automatic time_t sat_add(input time_t a, input logic [15:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + (TimeW+1)'(b);
    return s[TimeW] ? '1 : s[TimeW-1:0];
  endfunction

endpackage

[rtl/nav_estimator_health_fsm.sv]
// Navigation health supervisor: status state machine, timers and quality pipeline.
//
// Usage:
//   Request channel (req_valid / req_stall) carries func, dt_us, odom_valid and
//   imu_ok. func 0 is an update tick, 1 an impact event, 2 a relocalize event,
//   3 a no-op that just reports the current health.
//   Result channel (res_valid / res_stall) returns status, validity and a
//   Q1.15 quality for every request, in request order.
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data);
//   write it only while no request is in flight.
// Timing:
//   One request is accepted per cycle while req_stall is low. The health state
//   is updated as the request leaves stage 0, then the quality is formed over
//   three more stages (offset, reciprocal multiply, remainder correction of
//   the divide by 78125) before the result is registered.
// Reset:
//   rst (synchronous) restores the register defaults, returns the status to
//   init with all timers cleared, and empties the pipeline.
// Stall:
//   A stalled result holds; the pipeline keeps filling its empty stages and
//   raises req_stall only when every stage is occupied.
module nav_estimator_health_fsm (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  func,
  input  logic [15:0] dt_us,
  input  logic        odom_valid,
  input  logic        imu_ok,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  status,
  output logic [1:0]  validity,
  output logic [15:0] quality,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  typedef enum logic [2:0] {
    StInit        = 3'd0,
    StImuOnly     = 3'd1,
    StVisualAided = 3'd2,
    StTracking    = 3'd3,
    StDegraded    = 3'd4,
    StLost        = 3'd5,
    StRecovering  = 3'd6,
    StRelocalized = 3'd7
  } status_t;

  // Configuration registers
  neh_pkg::time_t degraded_after;
  neh_pkg::time_t lost_after;
  neh_pkg::time_t recover_hold;
  neh_pkg::time_t impact_blind;
  logic           impact_to_lost;

  // Health state
  status_t        cur_status, status_next;
  neh_pkg::time_t state_timer, state_timer_next;
  neh_pkg::time_t invalid_time, invalid_time_next;
  neh_pkg::time_t blind_left, blind_left_next;
  logic [15:0]    good_frames, good_frames_next;

  // Pipeline valid bits and advance enables
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  // Stage payloads
  logic [1:0]     p0_func;
  logic [15:0]    p0_dt;
  logic           p0_odom;
  logic           p0_imu;
  logic [2:0]     p1_status;
  neh_pkg::time_t p1_time;
  logic [2:0]     p2_status;
  logic [1:0]     p2_validity;
  logic [31:0]    p2_y;
  logic [2:0]     p3_status;
  logic [1:0]     p3_validity;
  logic [31:0]    p3_y;
  logic [15:0]    p3_q0;

  // Combinational terms
  logic           dt_ok, vo, blind_active, do_enter;
  neh_pkg::time_t st_sum, inv_sum, dt_ext, t_cap;
  logic [21:0]    y_base;
  logic [1:0]     y_validity;
  logic [31:0]    y_next;
  logic [47:0]    q_prod;
  logic [31:0]    q_rem;
  logic [15:0]    q_final;

  // Advance when the next slot is free or moving on
  assign rdy4      = !res_valid || !res_stall;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign req_stall = !rdy0;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      degraded_after <= neh_pkg::RstDegradedAfter;
      lost_after     <= neh_pkg::RstLostAfter;
      recover_hold   <= neh_pkg::RstRecoverHold;
      impact_blind   <= neh_pkg::RstImpactBlind;
      impact_to_lost <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        neh_pkg::CfgDegradedAfter: degraded_after <= cfg_data;
        neh_pkg::CfgLostAfter:     lost_after     <= cfg_data;
        neh_pkg::CfgRecoverHold:   recover_hold   <= cfg_data;
        neh_pkg::CfgImpactBlind:   impact_blind   <= cfg_data;
        neh_pkg::CfgImpactToLost:  impact_to_lost <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Next health state for the request in stage 0
  always_comb begin
    status_next       = cur_status;
    state_timer_next  = state_timer;
    invalid_time_next = invalid_time;
    blind_left_next   = blind_left;
    good_frames_next  = good_frames;
    do_enter          = 1'b0;
    dt_ext            = neh_pkg::time_t'(p0_dt);
    dt_ok             = (p0_dt >= neh_pkg::DtMinUs) && (p0_dt <= neh_pkg::DtMaxUs) && p0_imu;
    st_sum            = neh_pkg::sat_add(state_timer, p0_dt);
    inv_sum           = neh_pkg::sat_add(invalid_time, p0_dt);
    blind_active      = (blind_left != '0);
    vo                = p0_odom && !blind_active;
    case (p0_func)
      neh_pkg::FuncTick: begin
        if (!dt_ok) begin
          status_next = StDegraded;
        end else begin
          state_timer_next = st_sum;
          if (blind_active) begin
            blind_left_next = (blind_left > dt_ext) ? blind_left - dt_ext : '0;
          end
          if (vo) begin
            invalid_time_next = '0;
            if (good_frames != '1) begin
              good_frames_next = good_frames + 16'd1;
            end
          end else begin
            invalid_time_next = inv_sum;
            good_frames_next  = '0;
          end
          case (cur_status)
            StInit: begin
              status_next = vo ? StVisualAided : StImuOnly;
              do_enter    = 1'b1;
            end
            StImuOnly: begin
              if (vo) begin
                status_next = StVisualAided;
                do_enter    = 1'b1;
              end else if (invalid_time_next >= degraded_after) begin
                status_next = StDegraded;
                do_enter    = 1'b1;
              end
            end
            StVisualAided: begin
              if (!vo) begin
                status_next = StImuOnly;
                do_enter    = 1'b1;
              end else if (good_frames_next >= neh_pkg::GoodFramesNeeded) begin
                status_next = StTracking;
                do_enter    = 1'b1;
              end
            end
            StTracking: begin
              if (invalid_time_next >= degraded_after) begin
                status_next = StDegraded;
                do_enter    = 1'b1;
              end
            end
            StDegraded: begin
              if (vo) begin
                status_next = StRecovering;
                do_enter    = 1'b1;
              end else if (invalid_time_next >= lost_after) begin
                status_next = StLost;
                do_enter    = 1'b1;
              end
            end
            StLost: begin
              if (vo) begin
                status_next = StRecovering;
                do_enter    = 1'b1;
              end
            end
            StRecovering: begin
              if (vo && (st_sum >= recover_hold)) begin
                status_next = StRelocalized;
                do_enter    = 1'b1;
              end else if (!vo && (invalid_time_next >= lost_after)) begin
                status_next = StLost;
                do_enter    = 1'b1;
              end
            end
            default: begin
              status_next = StTracking;
              do_enter    = 1'b1;
            end
          endcase
        end
      end
      neh_pkg::FuncImpact: begin
        blind_left_next  = impact_blind;
        good_frames_next = '0;
        status_next      = impact_to_lost ? StLost : StDegraded;
        do_enter         = 1'b1;
      end
      neh_pkg::FuncReloc: begin
        status_next       = StRelocalized;
        invalid_time_next = '0;
        good_frames_next  = '0;
        do_enter          = 1'b1;
      end
      default: ;
    endcase
    // Entering a state restarts its timer
    if (do_enter) begin
      state_timer_next = '0;
    end
  end

  // Quality dividend from the committed status and invalid time
  always_comb begin
    t_cap      = '0;
    y_base     = '0;
    y_validity = neh_pkg::ValInvalid;
    y_next     = '0;
    case (p1_status)
      StTracking, StRelocalized: begin
        y_validity = neh_pkg::ValValid;
        t_cap      = (p1_time > neh_pkg::TrkTimeCap) ? neh_pkg::TrkTimeCap : p1_time;
        y_base     = neh_pkg::TrkBase - t_cap[21:0];
        y_next     = (32'(y_base) << 9) + (32'(y_base) << 7);
      end
      StImuOnly, StVisualAided, StDegraded, StRecovering: begin
        y_validity = neh_pkg::ValDegraded;
        t_cap      = (p1_time > neh_pkg::AidTimeCap) ? neh_pkg::AidTimeCap : p1_time;
        y_base     = neh_pkg::AidBase - t_cap[21:0];
        y_next     = 32'(y_base) << 9;
      end
      default: ;
    endcase
  end

  // Reciprocal multiply, then correct the low quotient by one
  assign q_prod  = 48'(p2_y) * 48'(neh_pkg::QRecip);
  assign q_rem   = p3_y - 32'(p3_q0) * neh_pkg::QDivisor;
  assign q_final = p3_q0 + 16'(q_rem >= neh_pkg::QDivisor);

  // Pipeline control and health state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0           <= 1'b0;
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      res_valid    <= 1'b0;
      cur_status   <= StInit;
      state_timer  <= '0;
      invalid_time <= '0;
      blind_left   <= '0;
      good_frames  <= '0;
    end else begin
      if (rdy0) v0 <= req_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) res_valid <= v3;
      // Commit the state as the request leaves stage 0
      if (v0 && rdy1) begin
        cur_status   <= status_next;
        state_timer  <= state_timer_next;
        invalid_time <= invalid_time_next;
        blind_left   <= blind_left_next;
        good_frames  <= good_frames_next;
      end
    end
  end

  // Pipeline payloads
  always_ff @(posedge clk) begin
    if (req_valid && rdy0) begin
      p0_func <= func;
      p0_dt   <= dt_us;
      p0_odom <= odom_valid;
      p0_imu  <= imu_ok;
    end
    if (v0 && rdy1) begin
      p1_status <= status_next;
      p1_time   <= invalid_time_next;
    end
    if (v1 && rdy2) begin
      p2_status   <= p1_status;
      p2_validity <= y_validity;
      p2_y        <= y_next;
    end
    if (v2 && rdy3) begin
      p3_status   <= p2_status;
      p3_validity <= p2_validity;
      p3_y        <= p2_y;
      p3_q0       <= q_prod[47:32];
    end
    if (v3 && rdy4) begin
      status   <= p3_status;
      validity <= p3_validity;
      quality  <= q_final;
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the navigation health supervisor.
module tb;

  // Estimator status codes as reported on the status port
  typedef enum logic [2:0] {
    StInit        = 3'd0,
    StImuOnly     = 3'd1,
    StVisualAided = 3'd2,
    StTracking    = 3'd3,
    StDegraded    = 3'd4,
    StLost        = 3'd5,
    StRecovering  = 3'd6,
    StRelocalized = 3'd7
  } status_t;

  // Function code that only reports the current health
  localparam logic [1:0] FuncReport = 2'd3;

  localparam int QuietLimit = 1000;
  localparam int PhaseCount = 13;
  localparam int PhaseItems = 115;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  validity;
    logic [15:0] quality;
  } health_t;

  // Health predictor: mirrors the supervisor state and queues the expected reports
  class health_tracker;
    bit [31:0] degraded_after;
    bit [31:0] lost_after;
    bit [31:0] recover_hold;
    bit [31:0] impact_blind;
    bit        impact_to_lost;
    status_t   cur;
    bit [31:0] state_timer;
    bit [31:0] invalid_time;
    bit [31:0] blind_left;
    bit [15:0] good_frames;
    health_t   expected_health[$];
    int unsigned mismatches;

    function new();
      degraded_after = 32'd500000;
      lost_after     = 32'd2000000;
      recover_hold   = 32'd300000;
      impact_blind   = 32'd200000;
      impact_to_lost = 1'b0;
      cur            = StInit;
      state_timer    = '0;
      invalid_time   = '0;
      blind_left     = '0;
      good_frames    = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [25:0] v);
      case (idx)
        neh_pkg::CfgDegradedAfter: degraded_after = 32'(v);
        neh_pkg::CfgLostAfter:     lost_after = 32'(v);
        neh_pkg::CfgRecoverHold:   recover_hold = 32'(v);
        neh_pkg::CfgImpactBlind:   impact_blind = 32'(v);
        neh_pkg::CfgImpactToLost:  impact_to_lost = v[0];
        default: ;
      endcase
    endfunction

    function bit [31:0] timer_add(bit [31:0] a, bit [15:0] b);
      bit [32:0] s;
      s = {1'b0, a} + 33'(b);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function void enter(status_t st);
      cur = st;
      state_timer = '0;
    endfunction

    // Advance the health state by one request and queue the report it produces
    function void note_request(logic [1:0] fn, logic [15:0] dt, logic ov, logic imu);
      bit vo;
      health_t h;
      longint unsigned t;
      longint unsigned q;
      vo = ov;
      case (fn)
        neh_pkg::FuncTick: begin
          if (dt < neh_pkg::DtMinUs || dt > neh_pkg::DtMaxUs || !imu) begin
            // implausible tick: degrade, leave timers alone
            cur = StDegraded;
          end else begin
            state_timer = timer_add(state_timer, dt);
            // ignore odometry while the impact blind time runs
            if (blind_left != 0) begin
              blind_left = (blind_left > 32'(dt)) ? blind_left - 32'(dt) : '0;
              vo = 1'b0;
            end
            if (vo) begin
              invalid_time = '0;
              if (good_frames != 16'hFFFF) good_frames++;
            end else begin
              invalid_time = timer_add(invalid_time, dt);
              good_frames = '0;
            end
            case (cur)
              StInit: enter(vo ? StVisualAided : StImuOnly);
              StImuOnly: begin
                if (vo) enter(StVisualAided);
                else if (invalid_time >= degraded_after) enter(StDegraded);
              end
              StVisualAided: begin
                if (!vo) enter(StImuOnly);
                else if (good_frames >= neh_pkg::GoodFramesNeeded) enter(StTracking);
              end
              StTracking: begin
                if (invalid_time >= degraded_after) enter(StDegraded);
              end
              StDegraded: begin
                if (vo) enter(StRecovering);
                else if (invalid_time >= lost_after) enter(StLost);
              end
              StLost: begin
                if (vo) enter(StRecovering);
              end
              StRecovering: begin
                if (vo && state_timer >= recover_hold) enter(StRelocalized);
                else if (!vo && invalid_time >= lost_after) enter(StLost);
              end
              default: enter(StTracking);
            endcase
          end
        end
        neh_pkg::FuncImpact: begin
          blind_left = impact_blind;
          good_frames = '0;
          enter(impact_to_lost ? StLost : StDegraded);
        end
        neh_pkg::FuncReloc: begin
          enter(StRelocalized);
          invalid_time = '0;
          good_frames = '0;
        end
        default: ;
      endcase

      // Form the report: validity class and floored Q1.15 quality
      h.status = cur;
      t = 64'(invalid_time);
      case (cur)
        StTracking, StRelocalized: begin
          h.validity = neh_pkg::ValValid;
          if (t >= 64'd1000000) begin
            q = 64'd24576;
          end else begin
            q = (64'd32768000000 - 64'd8192 * t) / 64'd1000000;
            if (q < 64'd24576) q = 64'd24576;
          end
        end
        StImuOnly, StVisualAided, StDegraded, StRecovering: begin
          h.validity = neh_pkg::ValDegraded;
          if (t >= 64'd2500000) begin
            q = 64'd6553;
          end else begin
            q = (64'd229376000000 - 64'd65536 * t) / 64'd10000000;
            if (q < 64'd6553) q = 64'd6553;
          end
        end
        default: begin
          h.validity = neh_pkg::ValInvalid;
          q = 64'd0;
        end
      endcase
      h.quality = q[15:0];
      expected_health.push_back(h);
    endfunction

    // Compare one delivered report against the oldest expectation
    function void check_report(logic [2:0] st, logic [1:0] va, logic [15:0] q);
      health_t h;
      if (expected_health.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: status %0d validity %0d quality %0d", st, va, q);
        return;
      end
      h = expected_health.pop_front();
      if (st !== h.status || va !== h.validity || q !== h.quality) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report mismatch: expected status %0d validity %0d quality %0d, got %0d %0d %0d",
                   h.status, h.validity, h.quality, st, va, q);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  func;
  logic [15:0] dt_us;
  logic        odom_valid;
  logic        imu_ok;
  logic        res_valid;
  logic        res_stall;
  logic [2:0]  status;
  logic [1:0]  validity;
  logic [15:0] quality;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [25:0] cfg_data;

  health_tracker health;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  int unsigned   quiet;

  nav_estimator_health_fsm i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .dt_us      (dt_us),
    .odom_valid (odom_valid),
    .imu_ok     (imu_ok),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .status     (status),
    .validity   (validity),
    .quality    (quality),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Consume reports and stall the result channel at random
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) health.check_report(status, validity, quality);
    res_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_req(input logic [1:0] fn, input logic [15:0] dt, input logic ov,
                          input logic imu);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid  <= 1'b1;
    func       <= fn;
    dt_us      <= dt;
    odom_valid <= ov;
    imu_ok     <= imu;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    health.note_request(fn, dt, ov, imu);
  endtask

  // Stop sending and wait until every expected report has come back
  task automatic drain();
    req_valid <= 1'b0;
    while (health.expected_health.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [25:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    health.write_reg(idx, v);
  endtask

  task automatic apply_config(input logic [25:0] deg, input logic [25:0] lost,
                              input logic [25:0] hold, input logic [25:0] blind,
                              input logic loi);
    write_reg(neh_pkg::CfgDegradedAfter, deg);
    write_reg(neh_pkg::CfgLostAfter, lost);
    write_reg(neh_pkg::CfgRecoverHold, hold);
    write_reg(neh_pkg::CfgImpactBlind, blind);
    write_reg(neh_pkg::CfgImpactToLost, {25'd0, loi});
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [25:0] pick_time();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 26'd0;
    if (r == 1) return 26'd60000000;
    if (r < 5) return 26'($urandom_range(300000));
    if (r < 8) return 26'($urandom_range(3000000));
    return 26'($urandom_range(60000000));
  endfunction

  // Mostly plausible ticks with runs of good and bad odometry, plus events and noise
  task automatic run_traffic(input int n);
    bit vo_mode;
    int unsigned r;
    logic [15:0] dt;
    vo_mode = 1'b1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(vo_mode ? 14 : 29) == 0) vo_mode = !vo_mode;
      r = $urandom_range(99);
      if (r < 3) begin
        send_req(neh_pkg::FuncImpact, 16'($urandom), 1'($urandom), 1'($urandom));
      end else if (r < 5) begin
        send_req(neh_pkg::FuncReloc, 16'($urandom), 1'($urandom), 1'($urandom));
      end else if (r < 7) begin
        send_req(FuncReport, 16'($urandom), 1'($urandom), 1'($urandom));
      end else if (r < 10) begin
        case ($urandom_range(2))
          0: send_req(neh_pkg::FuncTick, 16'($urandom_range(499)), 1'($urandom),
                      1'($urandom));
          1: send_req(neh_pkg::FuncTick, 16'($urandom_range(65535, 50001)), 1'($urandom),
                      1'($urandom));
          default: send_req(neh_pkg::FuncTick, 16'($urandom_range(50000, 500)),
                            1'($urandom), 1'b0);
        endcase
      end else begin
        case ($urandom_range(3))
          0: dt = 16'($urandom_range(2000, 500));
          1: dt = 16'($urandom_range(50000, 500));
          2: dt = 16'($urandom_range(50000, 20000));
          default: dt = $urandom_range(1) ? neh_pkg::DtMaxUs : neh_pkg::DtMinUs;
        endcase
        send_req(neh_pkg::FuncTick, dt, ($urandom_range(9) == 0) ? !vo_mode : vo_mode,
                 1'b1);
      end
    end
  endtask

  initial begin
    health         = new();
    send_idle_pct  = 30;
    recv_stall_pct = 63;
    rst            = 1'b1;
    req_valid      = 1'b0;
    func           = neh_pkg::FuncTick;
    dt_us          = '0;
    odom_valid     = 1'b0;
    imu_ok         = 1'b0;
    res_stall      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = neh_pkg::CfgDegradedAfter;
    cfg_data       = '0;
    quiet          = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: init report, first tick, bad ticks, recovery, impact blind time, events
    send_req(FuncReport, 16'd0, 1'b0, 1'b0);
    send_req(neh_pkg::FuncTick, 16'd500, 1'b0, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd499, 1'b1, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd50001, 1'b1, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd0, 1'b1, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd65535, 1'b1, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd500, 1'b1, 1'b0);
    send_req(neh_pkg::FuncTick, 16'd500, 1'b1, 1'b1);
    repeat (6) send_req(neh_pkg::FuncTick, 16'd50000, 1'b1, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd1000, 1'b0, 1'b1);
    send_req(neh_pkg::FuncImpact, 16'hFFFF, 1'b1, 1'b1);
    repeat (4) send_req(neh_pkg::FuncTick, 16'd50000, 1'b1, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd40000, 1'b1, 1'b1);
    send_req(neh_pkg::FuncReloc, 16'hFFFF, 1'b1, 1'b1);
    send_req(FuncReport, 16'hFFFF, 1'b1, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd50000, 1'b0, 1'b1);
    send_req(neh_pkg::FuncTick, 16'd50000, 1'b0, 1'b1);
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < PhaseCount; p++) begin
      if (p < 5) begin
        send_idle_pct  = 30;
        recv_stall_pct = 63;
      end else if (p < 9) begin
        send_idle_pct  = 63;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (p)
        0: apply_config(26'd0, 26'd0, 26'd0, 26'd0, 1'b0);
        1: apply_config(26'd60000000, 26'd60000000, 26'd60000000, 26'd60000000, 1'b1);
        2: apply_config(26'd500000, 26'd2000000, 26'd300000, 26'd200000, 1'b1);
        3: apply_config(26'd100000, 26'd400000, 26'd50000, 26'd60000, 1'b0);
        default: apply_config(pick_time(), pick_time(), pick_time(), pick_time(),
                              1'($urandom_range(1)));
      endcase
      run_traffic(PhaseItems);
      drain();
    end

    repeat (10) @(posedge clk);
    if (health.mismatches == 0 && health.expected_health.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/neh_pkg.sv
rtl/nav_estimator_health_fsm.sv
tb/tb.sv
